[hdl/mcrt_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-channel repeat timer package
// Shared types and constants for the timer bank: request payloads, command
// codes, sequencer states and the interface of the expiry step unit.
// ----------------------------------------------------------------------------
package mcrt_pkg;

    // Field widths of the request payloads.
    localparam int CMD_W  = 3;
    localparam int CH_W   = 3;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 16;
    localparam int MS_W   = 8;

    // Command codes carried in the input request.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_INIT    = 3'd1,
        CMD_START   = 3'd2,
        CMD_RESTART = 3'd3,
        CMD_PAUSE   = 3'd4,
        CMD_DETACH  = 3'd5,
        CMD_SERVICE = 3'd6
    } t_cmd;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESTART,
        ST_FLUSH
    } t_state;

    // Input request.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CH_W-1:0]   channel;
        logic [TIME_W-1:0] timeout_ms;
        logic [CNT_W-1:0]  repeat_count;
        logic              immediate_mode;
        logic              has_notify;
        logic [MS_W-1:0]   tick_ms;
    } t_in_req;

    // Output request, one per reported expiry.
    typedef struct packed {
        logic            fired;
        logic [CH_W-1:0] event_channel;
        logic            count_done;
        logic            last;
    } t_out_req;

    // Operands of the shared expiry step unit for one channel.
    typedef struct packed {
        logic              is_tick;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] threshold;
        logic [CNT_W-1:0]  remaining;
        logic [MS_W-1:0]   tick_ms;
        logic              counted;
        logic              fire_on_tick;
        logic              notify;
    } t_step_in;

    // Updates and event produced by the step unit for one channel.
    typedef struct packed {
        logic              elapsed_we;
        logic [TIME_W-1:0] elapsed;
        logic              remaining_we;
        logic [CNT_W-1:0]  remaining;
        logic              stop;
        logic              set_pending;
        logic              emit;
        logic              fired;
        logic              done;
    } t_step_out;

endpackage

[hdl/mcrt_step_unit.sv]
// ----------------------------------------------------------------------------
// Expiry step unit
// Shared arithmetic for one channel per cycle while the walk is not blocked: saturating elapsed-time add,
// threshold compare, repeat-count decrement and event decision.
// ----------------------------------------------------------------------------
module mcrt_step_unit (
    input  mcrt_pkg::t_step_in  i_step,
    output mcrt_pkg::t_step_out o_step
);

    logic [mcrt_pkg::TIME_W:0]   sum;
    logic [mcrt_pkg::TIME_W-1:0] sat;
    logic                        expire;
    logic [mcrt_pkg::CNT_W-1:0]  rem_dec;
    logic                        handle;
    logic                        done;

    // Saturating add of the tick and compare against the threshold.
    always_comb begin
        sum    = {1'b0, i_step.elapsed} + (mcrt_pkg::TIME_W + 1)'(i_step.tick_ms);
        sat    = sum[mcrt_pkg::TIME_W] ? '1 : sum[mcrt_pkg::TIME_W-1:0];
        expire = (sat >= i_step.threshold);
    end

    // Expiry handling: a service walk always handles, a tick walk only on
    // an expiry of an immediate channel.
    always_comb begin
        rem_dec = i_step.remaining - mcrt_pkg::CNT_W'(1);
        handle  = i_step.is_tick ? (expire && i_step.fire_on_tick) : 1'b1;
        done    = handle && i_step.counted && (rem_dec == '0);
    end

    // Updates for the channel state and the event.
    always_comb begin
        o_step.elapsed_we   = i_step.is_tick || done;
        o_step.elapsed      = (i_step.is_tick && !expire) ? sat : '0;
        o_step.remaining_we = handle && i_step.counted;
        o_step.remaining    = rem_dec;
        o_step.stop         = done;
        o_step.set_pending  = i_step.is_tick && expire && !i_step.fire_on_tick;
        o_step.emit         = handle && (i_step.notify || done);
        o_step.fired        = i_step.notify;
        o_step.done         = done;
    end

endmodule

[hdl/multi_channel_repeat_timer.sv]
// ----------------------------------------------------------------------------
// Multi-channel repeat timer
// Command-driven bank of timer channels with counted or periodic repeats,
// immediate or deferred expiry handling, and events in ascending channel order.
// ----------------------------------------------------------------------------
// Init, start, pause, detach and unused commands act from the idle state; restart also passes
// through the restart state, which clears the elapsed time and reloads the repeat count.
// Tick and service walk each channel in turn through the shared step unit, then release the
// final event in flush; an output stall on an event that must move on holds the walk or flush.
// Reset is synchronous: sequencer, channel flags and output valid clear at once.
// Time and count memories get no clearing pass; init writes each entry before use.
module multi_channel_repeat_timer #(
    parameter int NUM_TIMERS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mcrt_pkg::t_in_req  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mcrt_pkg::t_out_req o_out
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    // Sequencer.
    mcrt_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_walk_tick;
    logic [mcrt_pkg::MS_W-1:0] r_tick_ms;

    // Per-channel flags.
    logic [NUM_TIMERS-1:0] r_attached;
    logic [NUM_TIMERS-1:0] r_running;
    logic [NUM_TIMERS-1:0] r_counted;
    logic [NUM_TIMERS-1:0] r_fire_tick;
    logic [NUM_TIMERS-1:0] r_notify;
    logic [NUM_TIMERS-1:0] r_pending;

    // Per-channel time and count memories with registered reads.
    logic [mcrt_pkg::TIME_W-1:0] mem_elapsed   [NUM_TIMERS];
    logic [mcrt_pkg::TIME_W-1:0] mem_threshold [NUM_TIMERS];
    logic [mcrt_pkg::CNT_W-1:0]  mem_remaining [NUM_TIMERS];
    logic [mcrt_pkg::CNT_W-1:0]  mem_reload    [NUM_TIMERS];
    logic [mcrt_pkg::TIME_W-1:0] r_rd_elapsed;
    logic [mcrt_pkg::TIME_W-1:0] r_rd_threshold;
    logic [mcrt_pkg::CNT_W-1:0]  r_rd_remaining;
    logic [mcrt_pkg::CNT_W-1:0]  r_rd_reload;

    // Held event and output register.
    logic               r_hold_valid;
    mcrt_pkg::t_out_req r_hold;
    logic               r_out_valid;
    mcrt_pkg::t_out_req r_out;

    // Decode and control.
    logic                        accept;
    mcrt_pkg::t_cmd              in_cmd;
    logic                        ch_ok;
    logic [IDX_W-1:0]            ch_idx;
    logic                        eligible;
    logic                        out_free;
    logic                        blocked;
    logic                        advance;
    logic                        commit;
    mcrt_pkg::t_step_in          step_in;
    mcrt_pkg::t_step_out         step_out;
    logic [IDX_W-1:0]            wa;
    logic                        el_we;
    logic [mcrt_pkg::TIME_W-1:0] el_wd;
    logic                        rem_we;
    logic [mcrt_pkg::CNT_W-1:0]  rem_wd;
    logic                        cfg_we;
    logic                        out_load;
    mcrt_pkg::t_out_req          out_data;
    logic                        hold_load;
    logic                        hold_clear;
    mcrt_pkg::t_out_req          hold_data;

    assign o_in_stall  = (r_state != mcrt_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Request decode.
    assign accept = i_in_valid && !o_in_stall;
    assign in_cmd = mcrt_pkg::t_cmd'(i_in.command);
    assign ch_ok  = (32'(i_in.channel) < 32'(NUM_TIMERS));
    assign ch_idx = IDX_W'(i_in.channel);

    // Walk control: a channel takes part when attached and running (tick)
    // or attached and pending (service).
    assign eligible = r_attached[r_idx] &&
                      (r_walk_tick ? r_running[r_idx] : r_pending[r_idx]);
    assign out_free = !r_out_valid || !i_out_stall;
    assign blocked  = eligible && step_out.emit && r_hold_valid && !out_free;
    assign advance  = (r_state == mcrt_pkg::ST_WALK) && !blocked;
    assign commit   = (r_state == mcrt_pkg::ST_WALK) && eligible && !blocked;

    // Shared step unit operands for the channel under the walk index.
    always_comb begin
        step_in.is_tick      = r_walk_tick;
        step_in.elapsed      = r_rd_elapsed;
        step_in.threshold    = r_rd_threshold;
        step_in.remaining    = r_rd_remaining;
        step_in.tick_ms      = r_tick_ms;
        step_in.counted      = r_counted[r_idx];
        step_in.fire_on_tick = r_fire_tick[r_idx];
        step_in.notify       = r_notify[r_idx];
    end

    mcrt_step_unit u_step (
        .i_step (step_in),
        .o_step (step_out)
    );

    // Next state and walk index.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            mcrt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == mcrt_pkg::CMD_TICK || in_cmd == mcrt_pkg::CMD_SERVICE) begin
                        n_state = mcrt_pkg::ST_WALK;
                        n_idx   = '0;
                    end else if (in_cmd == mcrt_pkg::CMD_RESTART && ch_ok) begin
                        n_state = mcrt_pkg::ST_RESTART;
                        n_idx   = ch_idx;
                    end
                end
            end
            mcrt_pkg::ST_WALK: begin
                if (advance) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = mcrt_pkg::ST_FLUSH;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            mcrt_pkg::ST_RESTART: begin
                n_state = mcrt_pkg::ST_IDLE;
            end
            mcrt_pkg::ST_FLUSH: begin
                if (!r_hold_valid || out_free) begin
                    n_state = mcrt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mcrt_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory writes and event movement for each state.
    always_comb begin
        wa         = (r_state == mcrt_pkg::ST_IDLE) ? ch_idx : r_idx;
        el_we      = 1'b0;
        el_wd      = '0;
        rem_we     = 1'b0;
        rem_wd     = i_in.repeat_count;
        cfg_we     = 1'b0;
        out_load   = 1'b0;
        out_data   = r_hold;
        hold_load  = 1'b0;
        hold_clear = 1'b0;
        hold_data.fired         = step_out.fired;
        hold_data.event_channel = mcrt_pkg::CH_W'(r_idx);
        hold_data.count_done    = step_out.done;
        hold_data.last          = 1'b0;
        unique case (r_state)
            mcrt_pkg::ST_IDLE: begin
                if (accept && ch_ok && in_cmd == mcrt_pkg::CMD_INIT) begin
                    el_we  = 1'b1;
                    rem_we = 1'b1;
                    cfg_we = 1'b1;
                end else if (accept && ch_ok && in_cmd == mcrt_pkg::CMD_PAUSE) begin
                    el_we = 1'b1;
                end
            end
            mcrt_pkg::ST_RESTART: begin
                el_we  = 1'b1;
                rem_we = 1'b1;
                rem_wd = r_rd_reload;
            end
            mcrt_pkg::ST_WALK: begin
                if (commit) begin
                    el_we  = step_out.elapsed_we;
                    el_wd  = step_out.elapsed;
                    rem_we = step_out.remaining_we;
                    rem_wd = step_out.remaining;
                    if (step_out.emit) begin
                        // The previous event is now known not to be the last.
                        hold_load = 1'b1;
                        out_load  = r_hold_valid;
                    end
                end
            end
            mcrt_pkg::ST_FLUSH: begin
                if (r_hold_valid && out_free) begin
                    out_load      = 1'b1;
                    out_data.last = 1'b1;
                    hold_clear    = 1'b1;
                end
            end
            default: begin
                el_we = 1'b0;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcrt_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Walk operands latched with the request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_walk_tick <= (in_cmd == mcrt_pkg::CMD_TICK);
            r_tick_ms   <= i_in.tick_ms;
        end
    end

    // Channel flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attached  <= '0;
            r_running   <= '0;
            r_counted   <= '0;
            r_fire_tick <= '0;
            r_notify    <= '0;
            r_pending   <= '0;
        end else if (r_state == mcrt_pkg::ST_IDLE && accept && ch_ok) begin
            unique case (in_cmd)
                mcrt_pkg::CMD_INIT: begin
                    r_attached[ch_idx]  <= 1'b1;
                    r_counted[ch_idx]   <= (i_in.repeat_count != '0);
                    r_fire_tick[ch_idx] <= i_in.immediate_mode;
                    r_notify[ch_idx]    <= i_in.has_notify;
                end
                mcrt_pkg::CMD_START, mcrt_pkg::CMD_RESTART: begin
                    r_running[ch_idx] <= 1'b1;
                end
                mcrt_pkg::CMD_PAUSE: begin
                    r_running[ch_idx] <= 1'b0;
                end
                mcrt_pkg::CMD_DETACH: begin
                    r_attached[ch_idx] <= 1'b0;
                end
                default: begin
                    r_running <= r_running;
                end
            endcase
        end else if (commit) begin
            if (!r_walk_tick) begin
                r_pending[r_idx] <= 1'b0;
            end
            if (step_out.set_pending) begin
                r_pending[r_idx] <= 1'b1;
            end
            if (step_out.stop) begin
                r_running[r_idx] <= 1'b0;
            end
        end
    end

    // Memory writes.
    always_ff @(posedge i_clk) begin
        if (el_we) begin
            mem_elapsed[wa] <= el_wd;
        end
        if (rem_we) begin
            mem_remaining[wa] <= rem_wd;
        end
        if (cfg_we) begin
            mem_threshold[wa] <= i_in.timeout_ms;
            mem_reload[wa]    <= i_in.repeat_count;
        end
    end

    // Registered reads follow the next walk index, so the data matches r_idx.
    always_ff @(posedge i_clk) begin
        r_rd_elapsed   <= mem_elapsed[n_idx];
        r_rd_threshold <= mem_threshold[n_idx];
        r_rd_remaining <= mem_remaining[n_idx];
        r_rd_reload    <= mem_reload[n_idx];
    end

    // Held event: waits until the walk shows whether another one follows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (hold_load) begin
            r_hold_valid <= 1'b1;
        end else if (hold_clear) begin
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold_load) begin
            r_hold <= hold_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_data;
        end
    end

`ifndef SYNTH
    // No event is left behind once the sequencer is idle.
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcrt_pkg::ST_IDLE) |-> !r_hold_valid)
        else $error("held event remains while idle");

    // Draining the held event presents it as the final one.
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcrt_pkg::ST_FLUSH && r_hold_valid && out_free)
        |=> (o_out_valid && o_out.last))
        else $error("final event not marked last");

    // A blocked channel is retried, not skipped.
    a_blocked_holds_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcrt_pkg::ST_WALK && blocked)
        |=> (r_idx == $past(r_idx) && r_state == mcrt_pkg::ST_WALK))
        else $error("walk moved past a blocked channel");

    // The walk index stays within the channel bank.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_idx) < 32'(NUM_TIMERS)))
        else $error("walk index out of range");
`endif

endmodule
